// ----- hdl/rlcps_pkg.sv -----
`timescale 1ns / 1ps

package rlcps_pkg;

	localparam int PIXEL_COUNT_DEF = 4;
	localparam int TRAIL_SLOTS_DEF = 40;
	localparam int BITS_PER_PIXEL  = 24;
	localparam int POS_W           = $clog2(BITS_PER_PIXEL);
	localparam int COLOR_W         = 8;
	localparam int INDEX_W         = 16;
	localparam int CFG_W           = 8;
	localparam int CFG_IDX_W       = 2;

	typedef enum logic [2:0] {
		OP_SET_PIXEL = 3'd0,
		OP_FILL_ALL  = 3'd1,
		OP_SHOW      = 3'd2,
		OP_TICK      = 3'd3,
		OP_ABORT     = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BUSY      = 2'd1,
		ST_BAD_INDEX = 2'd2
	} status_t;

	localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 2'd2;

	localparam logic [CFG_W-1:0] PERIOD_RST    = 8'd10;
	localparam logic [CFG_W-1:0] ONE_HIGH_RST  = 8'd6;
	localparam logic [CFG_W-1:0] ZERO_HIGH_RST = 8'd3;

endpackage

// ----- hdl/rlcps_if.sv -----
`timescale 1ns / 1ps

interface rlcps_in_if;
	logic                                 valid;
	logic                                 ready;
	logic [2:0]                           op;
	logic [rlcps_pkg::INDEX_W-1:0]        pixel_index;
	logic [rlcps_pkg::COLOR_W-1:0]        red;
	logic [rlcps_pkg::COLOR_W-1:0]        green;
	logic [rlcps_pkg::COLOR_W-1:0]        blue;

	modport source(output valid, op, pixel_index, red, green, blue, input ready);
	modport sink(input valid, op, pixel_index, red, green, blue, output ready);
endinterface

interface rlcps_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic       line_level;
	logic       idle;

	modport source(output valid, status, line_level, idle, input ready);
	modport sink(input valid, status, line_level, idle, output ready);
endinterface

// ----- hdl/rgb_led_chain_pwm_serializer.sv -----
`timescale 1ns / 1ps

// Serializer for a one-wire chain of RGB LEDs with PWM coded bits. Every item on in_ch is
// answered by exactly one result on out_ch, and one item is taken in every clock cycle as
// long as the result register ahead of out_ch is empty or being drained: the whole update
// for an item is one pass of logic from the pixel store and frame counters into that
// register. The pixel store is held in flip-flops, cleared by reset. A show item starts a
// frame of 1 + PIXEL_COUNT*24 + TRAIL_SLOTS slots, each slot lasting period_ticks tick items
// (at least one), so a frame takes that many slots times period_ticks transfers of tick
// items; the line level after each item is reported in its result.
module rgb_led_chain_pwm_serializer #(
	parameter int PIXEL_COUNT = rlcps_pkg::PIXEL_COUNT_DEF,
	parameter int TRAIL_SLOTS = rlcps_pkg::TRAIL_SLOTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	rlcps_in_if.sink                            in_ch,
	rlcps_out_if.source                         out_ch,
	input  logic                                cfg_we,
	input  logic [rlcps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rlcps_pkg::CFG_W-1:0]         cfg_data
);

	localparam int DATA_SLOTS  = PIXEL_COUNT * rlcps_pkg::BITS_PER_PIXEL;
	localparam int FRAME_SLOTS = 1 + DATA_SLOTS + TRAIL_SLOTS;
	localparam int SLOT_W      = $clog2(FRAME_SLOTS + 1);
	localparam int PIX_W       = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
	localparam int PIXEL_W     = rlcps_pkg::BITS_PER_PIXEL;
	localparam int POS_W       = rlcps_pkg::POS_W;
	localparam int CW          = rlcps_pkg::CFG_W;

	logic [PIXEL_W-1:0] pixel_store_q [PIXEL_COUNT];
	logic               sending_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [CW-1:0]      tick_q;
	logic [CW-1:0]      active_q;
	logic [PIX_W-1:0]   pix_q;
	logic [POS_W-1:0]   pos_q;

	logic [CW-1:0] period_q;
	logic [CW-1:0] one_high_q;
	logic [CW-1:0] zero_high_q;

	logic       res_valid_q;
	logic [1:0] res_status_q;
	logic       res_line_q;
	logic       res_idle_q;

	logic               accept;
	logic               bad_index;
	logic [PIXEL_W-1:0] color;
	logic               wr_one;
	logic               wr_all;
	logic [PIX_W-1:0]   wr_addr;

	logic                  sending_d;
	logic [SLOT_W-1:0]     slot_d;
	logic [CW-1:0]         tick_d;
	logic [CW-1:0]         active_d;
	logic [PIX_W-1:0]      pix_d;
	logic [POS_W-1:0]      pos_d;
	rlcps_pkg::status_t    status_d;
	logic [SLOT_W-1:0]     slot_inc;
	logic                  cur_bit;

	assign in_ch.ready = !res_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;
	assign bad_index   = in_ch.pixel_index >= rlcps_pkg::INDEX_W'(PIXEL_COUNT);
	assign color       = {in_ch.green, in_ch.red, in_ch.blue};
	assign wr_addr     = in_ch.pixel_index[PIX_W-1:0];
	assign slot_inc    = slot_q + SLOT_W'(1);
	assign cur_bit     = pixel_store_q[pix_q][POS_W'(PIXEL_W - 1) - pos_q];

	always_comb begin
		sending_d = sending_q;
		slot_d    = slot_q;
		tick_d    = tick_q;
		active_d  = active_q;
		pix_d     = pix_q;
		pos_d     = pos_q;
		status_d  = rlcps_pkg::ST_OK;
		wr_one    = 1'b0;
		wr_all    = 1'b0;
		case (rlcps_pkg::op_t'(in_ch.op))
			rlcps_pkg::OP_SET_PIXEL: begin
				if (bad_index) begin
					status_d = rlcps_pkg::ST_BAD_INDEX;
				end else if (sending_q) begin
					status_d = rlcps_pkg::ST_BUSY;
				end else begin
					wr_one = 1'b1;
				end
			end
			rlcps_pkg::OP_FILL_ALL: begin
				if (sending_q) begin
					status_d = rlcps_pkg::ST_BUSY;
				end else begin
					wr_all = 1'b1;
				end
			end
			rlcps_pkg::OP_SHOW: begin
				if (sending_q) begin
					status_d = rlcps_pkg::ST_BUSY;
				end else begin
					sending_d = 1'b1;
					slot_d    = '0;
					tick_d    = '0;
					active_d  = '0;
					pix_d     = '0;
					pos_d     = '0;
				end
			end
			rlcps_pkg::OP_TICK: begin
				if (sending_q) begin
					if ({1'b0, tick_q} + 9'd1 >= {1'b0, period_q}) begin
						tick_d = '0;
						slot_d = slot_inc;
						if (slot_inc >= SLOT_W'(FRAME_SLOTS)) begin
							sending_d = 1'b0;
							slot_d    = '0;
							active_d  = '0;
						end else if (slot_inc <= SLOT_W'(DATA_SLOTS)) begin
							// The next data bit is tracked by pixel and bit position.
							active_d = cur_bit ? one_high_q : zero_high_q;
							if (pos_q == POS_W'(PIXEL_W - 1)) begin
								pos_d = '0;
								if (pix_q != PIX_W'(PIXEL_COUNT - 1)) begin
									pix_d = pix_q + PIX_W'(1);
								end
							end else begin
								pos_d = pos_q + POS_W'(1);
							end
						end else begin
							active_d = '0;
						end
					end else begin
						tick_d = tick_q + CW'(1);
					end
				end
			end
			rlcps_pkg::OP_ABORT: begin
				sending_d = 1'b0;
				slot_d    = '0;
				tick_d    = '0;
				active_d  = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PIXEL_COUNT; i++) begin
				pixel_store_q[i] <= '0;
			end
		end else if (accept) begin
			for (int i = 0; i < PIXEL_COUNT; i++) begin
				if (wr_all || (wr_one && wr_addr == PIX_W'(i))) begin
					pixel_store_q[i] <= color;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sending_q <= 1'b0;
			slot_q    <= '0;
			tick_q    <= '0;
			active_q  <= '0;
			pix_q     <= '0;
			pos_q     <= '0;
		end else if (accept) begin
			sending_q <= sending_d;
			slot_q    <= slot_d;
			tick_q    <= tick_d;
			active_q  <= active_d;
			pix_q     <= pix_d;
			pos_q     <= pos_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= rlcps_pkg::PERIOD_RST;
			one_high_q  <= rlcps_pkg::ONE_HIGH_RST;
			zero_high_q <= rlcps_pkg::ZERO_HIGH_RST;
		end else if (cfg_we) begin
			if (cfg_index == rlcps_pkg::REG_PERIOD) begin
				period_q <= cfg_data;
			end
			if (cfg_index == rlcps_pkg::REG_ONE_HIGH) begin
				one_high_q <= cfg_data;
			end
			if (cfg_index == rlcps_pkg::REG_ZERO_HIGH) begin
				zero_high_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (in_ch.ready) begin
			res_valid_q <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_status_q <= status_d;
			res_line_q   <= sending_d && (tick_d < active_d);
			res_idle_q   <= !sending_d;
		end
	end

	assign out_ch.valid      = res_valid_q;
	assign out_ch.status     = res_status_q;
	assign out_ch.line_level = res_line_q;
	assign out_ch.idle       = res_idle_q;

	a_idle_counters_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!sending_q |-> (tick_q == '0) && (active_q == '0) && (slot_q == '0))
		else $error("frame counters not clear while idle");

	a_slot_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		sending_q |-> slot_q < SLOT_W'(FRAME_SLOTS))
		else $error("slot counter beyond frame");

	a_idle_line_low: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_idle_q |-> !res_line_q)
		else $error("line high while idle");

	a_show_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !sending_q && (in_ch.op == rlcps_pkg::OP_SHOW) |=> sending_q)
		else $error("show transfer did not start a frame");

	a_bad_index: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (in_ch.op == rlcps_pkg::OP_SET_PIXEL) && bad_index
		|=> res_status_q == rlcps_pkg::ST_BAD_INDEX)
		else $error("bad pixel index not reported");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;

	localparam int FRAME_SLOTS = 1 + rlcps_pkg::PIXEL_COUNT_DEF * rlcps_pkg::BITS_PER_PIXEL
		+ rlcps_pkg::TRAIL_SLOTS_DEF;
	localparam int DATA_SLOTS  = rlcps_pkg::PIXEL_COUNT_DEF * rlcps_pkg::BITS_PER_PIXEL;
	localparam int PHASE_ITEMS = 225;
	localparam logic [rlcps_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

	typedef struct packed {
		logic [2:0]                    op;
		logic [rlcps_pkg::INDEX_W-1:0] index;
		logic [7:0]                    red;
		logic [7:0]                    green;
		logic [7:0]                    blue;
	} led_cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic       line_level;
		logic       idle;
	} led_resp_t;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [rlcps_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [rlcps_pkg::CFG_W-1:0]     cfg_data;

	rlcps_in_if  in_ch();
	rlcps_out_if out_ch();

	rgb_led_chain_pwm_serializer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	led_cmd_t  cmd_queue[$];
	led_resp_t resp_queue[$];
	int        cmd_total;
	int        err_count;
	int        src_idle_pct;
	int        snk_stall_pct;

	logic [23:0] grb_store[rlcps_pkg::PIXEL_COUNT_DEF];
	logic        frame_on;
	int          slot_num;
	logic [7:0]  tick_num;
	logic [7:0]  slot_high_ticks;
	logic [7:0]  period_reg;
	logic [7:0]  one_high_reg;
	logic [7:0]  zero_high_reg;

	function automatic logic [7:0] slot_compare(input int slot);
		int bit_num;
		if (slot == 0 || slot > DATA_SLOTS)
			return 8'd0;
		bit_num = slot - 1;
		return grb_store[bit_num / rlcps_pkg::BITS_PER_PIXEL]
			[23 - bit_num % rlcps_pkg::BITS_PER_PIXEL] ? one_high_reg : zero_high_reg;
	endfunction

	function automatic void clear_frame();
		frame_on        = 1'b0;
		slot_num        = 0;
		tick_num        = 8'd0;
		slot_high_ticks = 8'd0;
	endfunction

	function automatic led_resp_t advance_chain(input led_cmd_t cmd);
		led_resp_t resp;
		resp.status = rlcps_pkg::ST_OK;
		case (cmd.op)
			rlcps_pkg::OP_SET_PIXEL: begin
				if (cmd.index >= rlcps_pkg::PIXEL_COUNT_DEF)
					resp.status = rlcps_pkg::ST_BAD_INDEX;
				else if (frame_on)
					resp.status = rlcps_pkg::ST_BUSY;
				else
					grb_store[cmd.index] = {cmd.green, cmd.red, cmd.blue};
			end
			rlcps_pkg::OP_FILL_ALL: begin
				if (frame_on)
					resp.status = rlcps_pkg::ST_BUSY;
				else
					foreach (grb_store[i])
						grb_store[i] = {cmd.green, cmd.red, cmd.blue};
			end
			rlcps_pkg::OP_SHOW: begin
				if (frame_on) begin
					resp.status = rlcps_pkg::ST_BUSY;
				end else begin
					clear_frame();
					frame_on = 1'b1;
				end
			end
			rlcps_pkg::OP_TICK: begin
				if (frame_on) begin
					if (int'(tick_num) + 1 >= int'(period_reg)) begin
						tick_num = 8'd0;
						slot_num++;
						if (slot_num >= FRAME_SLOTS)
							clear_frame();
						else
							slot_high_ticks = slot_compare(slot_num);
					end else begin
						tick_num++;
					end
				end
			end
			rlcps_pkg::OP_ABORT: clear_frame();
			default: ;
		endcase
		resp.line_level = frame_on && (tick_num < slot_high_ticks);
		resp.idle       = !frame_on;
		return resp;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("Test completed with failures");
		$finish;
	end

	always @(posedge clk) begin
		led_cmd_t taken;
		led_cmd_t nxt;
		if (in_ch.valid && in_ch.ready) begin
			taken = {in_ch.op, in_ch.pixel_index, in_ch.red, in_ch.green, in_ch.blue};
			resp_queue.push_back(advance_chain(taken));
		end
		if (!in_ch.valid || in_ch.ready) begin
			if (cmd_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				nxt = cmd_queue.pop_front();
				in_ch.valid       <= 1'b1;
				in_ch.op          <= nxt.op;
				in_ch.pixel_index <= nxt.index;
				in_ch.red         <= nxt.red;
				in_ch.green       <= nxt.green;
				in_ch.blue        <= nxt.blue;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		led_resp_t want;
		if (out_ch.valid && out_ch.ready) begin
			if (resp_queue.size() == 0) begin
				$error("Result transfer arrived with no expectation pending.");
				err_count++;
			end else begin
				want = resp_queue.pop_front();
				if (out_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, out_ch.status);
					err_count++;
				end
				if (out_ch.line_level !== want.line_level) begin
					$error("line_level: expected %0d, got %0d", want.line_level,
						out_ch.line_level);
					err_count++;
				end
				if (out_ch.idle !== want.idle) begin
					$error("idle: expected %0d, got %0d", want.idle, out_ch.idle);
					err_count++;
				end
			end
		end
		out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
	end

	task automatic push_cmd(input logic [2:0] op, input logic [rlcps_pkg::INDEX_W-1:0] index,
		input logic [7:0] red, input logic [7:0] green, input logic [7:0] blue);
		cmd_queue.push_back('{op, index, red, green, blue});
		cmd_total++;
	endtask

	function automatic logic [rlcps_pkg::INDEX_W-1:0] random_index();
		if ($urandom_range(99) < 12)
			return rlcps_pkg::INDEX_W'($urandom_range(0, 65535));
		return rlcps_pkg::INDEX_W'($urandom_range(0, rlcps_pkg::PIXEL_COUNT_DEF - 1));
	endfunction

	task automatic push_random_color(input logic [2:0] op);
		push_cmd(op, random_index(), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
	endtask

	// Noise is mostly busy writes and shows; an abort is rare so that frames can finish.
	task automatic push_noise();
		int pick;
		pick = $urandom_range(0, 39);
		if (pick < 14)
			push_random_color(rlcps_pkg::OP_SET_PIXEL);
		else if (pick < 20)
			push_random_color(rlcps_pkg::OP_FILL_ALL);
		else if (pick < 30)
			push_random_color(rlcps_pkg::OP_SHOW);
		else if (pick < 39)
			push_random_color(3'(rlcps_pkg::OP_ABORT) + 3'($urandom_range(1, 3)));
		else
			push_random_color(rlcps_pkg::OP_ABORT);
	endtask

	task automatic add_frame_run(input int eff_period, input int budget);
		int n_set;
		int n_ticks;
		if ($urandom_range(99) < 30)
			push_random_color(rlcps_pkg::OP_ABORT);
		if ($urandom_range(99) < 25)
			push_random_color(rlcps_pkg::OP_FILL_ALL);
		n_set = $urandom_range(0, 4);
		repeat (n_set)
			push_random_color(rlcps_pkg::OP_SET_PIXEL);
		push_random_color(rlcps_pkg::OP_SHOW);
		if ($urandom_range(99) < 60)
			n_ticks = FRAME_SLOTS * eff_period + $urandom_range(0, 8);
		else
			n_ticks = $urandom_range(1, FRAME_SLOTS * eff_period);
		if (n_ticks > 450)
			n_ticks = $urandom_range(100, 450);
		if (n_ticks > budget)
			n_ticks = (budget < 1) ? 1 : budget;
		repeat (n_ticks) begin
			if ($urandom_range(99) < 5)
				push_noise();
			push_random_color(rlcps_pkg::OP_TICK);
		end
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (cmd_queue.size() != 0 || in_ch.valid || resp_queue.size() != 0);
	endtask

	task automatic write_reg(input logic [rlcps_pkg::CFG_IDX_W-1:0] index,
		input logic [rlcps_pkg::CFG_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (index)
			rlcps_pkg::REG_PERIOD:    period_reg    = data;
			rlcps_pkg::REG_ONE_HIGH:  one_high_reg  = data;
			rlcps_pkg::REG_ZERO_HIGH: zero_high_reg = data;
			default: ;
		endcase
	endtask

	initial begin
		int period_set[5]  = '{2, 1, 3, 255, 0};
		int one_set[5]     = '{1, 255, 2, 255, 0};
		int zero_set[5]    = '{0, 0, 1, 128, 255};
		int src_set[5]     = '{0, 82, 0, 35, 0};
		int snk_set[5]     = '{0, 0, 82, 35, 0};
		int phase_start;

		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = '0;
		cfg_data          = '0;
		in_ch.valid       = 1'b0;
		in_ch.op          = rlcps_pkg::OP_TICK;
		in_ch.pixel_index = '0;
		in_ch.red         = '0;
		in_ch.green       = '0;
		in_ch.blue        = '0;
		out_ch.ready      = 1'b0;
		cmd_total         = 0;
		err_count         = 0;
		src_idle_pct      = 0;
		snk_stall_pct     = 0;
		foreach (grb_store[i])
			grb_store[i] = '0;
		clear_frame();
		period_reg    = rlcps_pkg::PERIOD_RST;
		one_high_reg  = rlcps_pkg::ONE_HIGH_RST;
		zero_high_reg = rlcps_pkg::ZERO_HIGH_RST;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Store writes, bad indexes, a frame start with busy answers, unused codes, aborts.
		push_cmd(rlcps_pkg::OP_FILL_ALL, 16'h0000, 8'hA5, 8'h5A, 8'hC3);
		push_cmd(rlcps_pkg::OP_SET_PIXEL, 16'h0000, 8'hFF, 8'h00, 8'hFF);
		push_cmd(rlcps_pkg::OP_SET_PIXEL, 16'h0003, 8'h00, 8'hFF, 8'h00);
		push_cmd(rlcps_pkg::OP_SET_PIXEL, 16'h0004, 8'h11, 8'h22, 8'h33);
		push_cmd(rlcps_pkg::OP_SET_PIXEL, 16'hFFFF, 8'h44, 8'h55, 8'h66);
		push_cmd(rlcps_pkg::OP_SHOW, 16'h0000, 8'h00, 8'h00, 8'h00);
		repeat (11)
			push_cmd(rlcps_pkg::OP_TICK, 16'h0000, 8'h00, 8'h00, 8'h00);
		push_cmd(rlcps_pkg::OP_SET_PIXEL, 16'h0001, 8'h12, 8'h34, 8'h56);
		push_cmd(rlcps_pkg::OP_SET_PIXEL, 16'h0009, 8'h12, 8'h34, 8'h56);
		push_cmd(rlcps_pkg::OP_FILL_ALL, 16'h0000, 8'h01, 8'h02, 8'h03);
		push_cmd(rlcps_pkg::OP_SHOW, 16'h0000, 8'h00, 8'h00, 8'h00);
		push_cmd(3'(rlcps_pkg::OP_ABORT) + 3'd1, 16'h0000, 8'h00, 8'h00, 8'h00);
		push_cmd(rlcps_pkg::OP_TICK, 16'h0000, 8'h00, 8'h00, 8'h00);
		push_cmd(rlcps_pkg::OP_ABORT, 16'h0000, 8'h00, 8'h00, 8'h00);
		push_cmd(rlcps_pkg::OP_TICK, 16'h0000, 8'h00, 8'h00, 8'h00);
		push_cmd(rlcps_pkg::OP_ABORT, 16'h0000, 8'h00, 8'h00, 8'h00);

		for (int ph = 0; ph < 5; ph++) begin
			wait_drained();
			write_reg(rlcps_pkg::REG_PERIOD, rlcps_pkg::CFG_W'(period_set[ph]));
			write_reg(rlcps_pkg::REG_ONE_HIGH, rlcps_pkg::CFG_W'(one_set[ph]));
			write_reg(rlcps_pkg::REG_ZERO_HIGH, rlcps_pkg::CFG_W'(zero_set[ph]));
			if (ph == 4)
				write_reg(REG_UNMAPPED, rlcps_pkg::CFG_W'($urandom_range(0, 255)));
			src_idle_pct  = src_set[ph];
			snk_stall_pct = snk_set[ph];
			phase_start   = cmd_total;
			while (cmd_total - phase_start < PHASE_ITEMS)
				add_frame_run((period_reg < 8'd1) ? 1 : int'(period_reg),
					PHASE_ITEMS - (cmd_total - phase_start));
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (err_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/rlcps_pkg.sv
hdl/rlcps_if.sv
hdl/rgb_led_chain_pwm_serializer.sv
sim/tb.sv
